// File: rtl/core/qhse_pkg.sv
// Shared widths, lane and register codes and coefficient helpers of the quintic Hermite evaluator.
package qhse_pkg;

  localparam int REG_W      = 32;
  localparam int NUM_REGS   = 6;
  localparam int IDX_W      = $clog2(NUM_REGS);
  localparam int T_W        = 17;
  localparam int FRAC_W     = 16;
  localparam int COEF_W     = 40;
  localparam int ACC_W      = 46;
  localparam int PROD_W     = ACC_W + T_W + 1;
  localparam int OUT_W      = 32;
  localparam int NUM_COEFS  = 6;
  localparam int NUM_LANES  = 4;
  localparam int NUM_STAGES = 5;

  localparam logic [T_W-1:0] T_ONE = T_W'(1) << FRAC_W;

  localparam logic [IDX_W-1:0] REG_START_VALUE     = IDX_W'(0);
  localparam logic [IDX_W-1:0] REG_END_VALUE       = IDX_W'(1);
  localparam logic [IDX_W-1:0] REG_START_SLOPE     = IDX_W'(2);
  localparam logic [IDX_W-1:0] REG_END_SLOPE       = IDX_W'(3);
  localparam logic [IDX_W-1:0] REG_START_CURVATURE = IDX_W'(4);
  localparam logic [IDX_W-1:0] REG_END_CURVATURE   = IDX_W'(5);

  localparam int K_A = 0;
  localparam int K_B = 1;
  localparam int K_C = 2;
  localparam int K_D = 3;
  localparam int K_E = 4;
  localparam int K_F = 5;

  localparam int LANE_POS  = 0;
  localparam int LANE_VEL  = 1;
  localparam int LANE_ACC  = 2;
  localparam int LANE_JERK = 3;

  typedef logic [NUM_COEFS-1:0][COEF_W-1:0] coefs_t;
  typedef logic [NUM_LANES-1:0][ACC_W-1:0]  lanes_t;
  typedef logic [NUM_LANES-1:0]             lane_mask_t;

  typedef struct packed {
    logic           valid;
    logic [T_W-1:0] t;
  } pipe_t;

  typedef struct packed {
    logic [OUT_W-1:0] position;
    logic [OUT_W-1:0] velocity;
    logic [OUT_W-1:0] acceleration;
    logic [OUT_W-1:0] jerk;
    logic             clipped;
  } result_t;

  function automatic logic signed [ACC_W-1:0] ext(input logic [COEF_W-1:0] k);
    return ACC_W'($signed(k));
  endfunction

  // value loaded into the lane that begins its chain at stage s
  function automatic lanes_t stage_init(input int s, input coefs_t c);
    lanes_t r;
    r = '0;
    unique case (s)
      0:       r[LANE_POS]  = ext(c[K_A]);
      1:       r[LANE_VEL]  = ext(c[K_A]) * ACC_W'(5);
      2:       r[LANE_ACC]  = ext(c[K_A]) * ACC_W'(20);
      3:       r[LANE_JERK] = ext(c[K_A]) * ACC_W'(60);
      default: r = '0;
    endcase
    return r;
  endfunction

  // term added after the multiply at stage s
  function automatic lanes_t stage_add(input int s, input coefs_t c);
    lanes_t r;
    r = '0;
    unique case (s)
      0: begin
        r[LANE_POS]  = ext(c[K_B]);
      end
      1: begin
        r[LANE_POS]  = ext(c[K_C]);
        r[LANE_VEL]  = ext(c[K_B]) * ACC_W'(4);
      end
      2: begin
        r[LANE_POS]  = ext(c[K_D]);
        r[LANE_VEL]  = ext(c[K_C]) * ACC_W'(3);
        r[LANE_ACC]  = ext(c[K_B]) * ACC_W'(12);
      end
      3: begin
        r[LANE_POS]  = ext(c[K_E]);
        r[LANE_VEL]  = ext(c[K_D]) * ACC_W'(2);
        r[LANE_ACC]  = ext(c[K_C]) * ACC_W'(6);
        r[LANE_JERK] = ext(c[K_B]) * ACC_W'(24);
      end
      4: begin
        r[LANE_POS]  = ext(c[K_F]);
        r[LANE_VEL]  = ext(c[K_E]);
        r[LANE_ACC]  = ext(c[K_D]) * ACC_W'(2);
        r[LANE_JERK] = ext(c[K_C]) * ACC_W'(6);
      end
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic lane_mask_t lane_start(input int s);
    lane_mask_t m;
    m = '0;
    for (int l = 0; l < NUM_LANES; l++) begin
      if (l == s) m[l] = 1'b1;
    end
    return m;
  endfunction

  function automatic lane_mask_t lane_on(input int s);
    lane_mask_t m;
    m = '0;
    for (int l = 0; l < NUM_LANES; l++) begin
      if (l <= s) m[l] = 1'b1;
    end
    return m;
  endfunction

endpackage

// File: rtl/core/qhse_if.sv
// Valid/ready channel interfaces for parameter input and evaluated results.
interface qhse_in_if;
  logic                      valid;
  logic                      ready;
  logic [qhse_pkg::T_W-1:0]  param_t;

  modport source (output valid, output param_t, input ready);
  modport sink   (input valid, input param_t, output ready);
endinterface

interface qhse_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [qhse_pkg::OUT_W-1:0] position;
  logic signed [qhse_pkg::OUT_W-1:0] velocity;
  logic signed [qhse_pkg::OUT_W-1:0] acceleration;
  logic signed [qhse_pkg::OUT_W-1:0] jerk;
  logic                              clipped;

  modport source (output valid, output position, output velocity, output acceleration,
                  output jerk, output clipped, input ready);
  modport sink   (input valid, input position, input velocity, input acceleration,
                  input jerk, input clipped, output ready);
endinterface

// File: rtl/core/qhse_coef.sv
// Boundary-condition registers and the coefficient rebuild.
module qhse_coef (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [qhse_pkg::IDX_W-1:0] cfg_index,
  input  logic [qhse_pkg::REG_W-1:0] cfg_wdata,
  output qhse_pkg::coefs_t           coefs
);
  import qhse_pkg::*;

  logic [REG_W-1:0] regs_r [NUM_REGS];
  coefs_t           coef_r;
  coefs_t           coef_nxt;

  function automatic logic signed [COEF_W-1:0] e(input logic [REG_W-1:0] x);
    return COEF_W'($signed(x));
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_REGS; i++) regs_r[i] <= '0;
    end else if (cfg_we && (cfg_index < IDX_W'(NUM_REGS))) begin
      regs_r[cfg_index] <= cfg_wdata;
    end
  end

  // coefficients held at twice their value
  always_comb begin
    logic signed [COEF_W-1:0] v0, v1, s0, s1, c0, c1;
    v0 = e(regs_r[REG_START_VALUE]);
    v1 = e(regs_r[REG_END_VALUE]);
    s0 = e(regs_r[REG_START_SLOPE]);
    s1 = e(regs_r[REG_END_SLOPE]);
    c0 = e(regs_r[REG_START_CURVATURE]);
    c1 = e(regs_r[REG_END_CURVATURE]);
    coef_nxt[K_A] = COEF_W'(12) * (v1 - v0) - COEF_W'(6) * (s0 + s1) + (c1 - c0);
    coef_nxt[K_B] = COEF_W'(30) * (v0 - v1) + COEF_W'(16) * s0 + COEF_W'(14) * s1
                    + COEF_W'(3) * c0 - COEF_W'(2) * c1;
    coef_nxt[K_C] = COEF_W'(20) * (v1 - v0) - COEF_W'(12) * s0 - COEF_W'(8) * s1
                    - COEF_W'(3) * c0 + c1;
    coef_nxt[K_D] = c0;
    coef_nxt[K_E] = s0 + s0;
    coef_nxt[K_F] = v0 + v0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r <= '0;
    end else begin
      coef_r <= coef_nxt;
    end
  end

  assign coefs = coef_r;

endmodule

// File: rtl/core/qhse_stage.sv
// One Horner step for all four derivative lanes: multiply by t, round, add term.
module qhse_stage (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   en,
  input  qhse_pkg::pipe_t        pipe_in,
  input  qhse_pkg::lanes_t       acc_prev,
  input  qhse_pkg::lanes_t       init,
  input  qhse_pkg::lanes_t       addend,
  input  qhse_pkg::lane_mask_t   start,
  input  qhse_pkg::lane_mask_t   on,
  output qhse_pkg::pipe_t        pipe_out,
  output qhse_pkg::lanes_t       acc_out
);
  import qhse_pkg::*;

  localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(1) <<< (FRAC_W - 1);

  logic signed [ACC_W-1:0]  x    [NUM_LANES];
  logic signed [PROD_W-1:0] prod [NUM_LANES];
  logic signed [PROD_W-1:0] rnd  [NUM_LANES];
  lanes_t                   acc_nxt;

  logic           valid_r;
  logic [T_W-1:0] t_r;
  lanes_t         acc_r;

  always_comb begin
    for (int l = 0; l < NUM_LANES; l++) begin
      x[l]    = start[l] ? $signed(init[l]) : $signed(acc_prev[l]);
      prod[l] = x[l] * $signed({1'b0, pipe_in.t});
      rnd[l]  = (prod[l] + ROUND_HALF) >>> FRAC_W;
      acc_nxt[l] = on[l] ? (rnd[l][ACC_W-1:0] + addend[l]) : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= pipe_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t_r   <= pipe_in.t;
      acc_r <= acc_nxt;
    end
  end

  assign pipe_out.valid = valid_r;
  assign pipe_out.t     = t_r;
  assign acc_out        = acc_r;

endmodule

// File: rtl/core/qhse_finish.sv
// Final halving, round, saturation to Q16.16 and the result register.
module qhse_finish (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               valid_in,
  input  qhse_pkg::lanes_t   acc_in,
  output logic               valid_out,
  output qhse_pkg::result_t  result
);
  import qhse_pkg::*;

  typedef struct packed {
    logic [OUT_W-1:0] q;
    logic             clip;
  } sat_t;

  function automatic sat_t sat(input logic [ACC_W-1:0] x);
    logic [ACC_W:0]   sum;
    logic [ACC_W-1:0] h;
    sat_t             r;
    sum = {x[ACC_W-1], x} + (ACC_W+1)'(1);
    h   = sum[ACC_W:1];
    if ((&h[ACC_W-1:OUT_W-1]) || !(|h[ACC_W-1:OUT_W-1])) begin
      r.q    = h[OUT_W-1:0];
      r.clip = 1'b0;
    end else begin
      r.q    = h[ACC_W-1] ? {1'b1, {(OUT_W-1){1'b0}}} : {1'b0, {(OUT_W-1){1'b1}}};
      r.clip = 1'b1;
    end
    return r;
  endfunction

  sat_t    s_pos, s_vel, s_acc, s_jerk;
  result_t res_nxt;
  result_t res_r;
  logic    valid_r;

  always_comb begin
    s_pos  = sat(acc_in[LANE_POS]);
    s_vel  = sat(acc_in[LANE_VEL]);
    s_acc  = sat(acc_in[LANE_ACC]);
    s_jerk = sat(acc_in[LANE_JERK]);
    res_nxt.position     = s_pos.q;
    res_nxt.velocity     = s_vel.q;
    res_nxt.acceleration = s_acc.q;
    res_nxt.jerk         = s_jerk.q;
    res_nxt.clipped      = s_pos.clip | s_vel.clip | s_acc.clip | s_jerk.clip;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_r <= res_nxt;
    end
  end

  assign valid_out = valid_r;
  assign result    = res_r;

endmodule

// File: rtl/core/quintic_hermite_spline_eval.sv
// Quintic Hermite segment evaluator: value and three derivatives at t.
// Pipeline from input transfer to result valid: input register, five Horner stages
// (one 46x18 multiplier per lane each), then rounding/saturation register.
// Throughput one item per cycle; the whole pipeline holds while the result waits.
// Configuration reaches the coefficients through the boundary registers, then the registered coefficient rebuild.
// Synchronous active-low reset clears the configuration registers, coefficients and all valid bits.
module quintic_hermite_spline_eval (
  input  logic                       clk,
  input  logic                       rst_n,
  qhse_in_if.sink                    in_ch,
  qhse_out_if.source                 out_ch,
  input  logic                       cfg_we,
  input  logic [qhse_pkg::IDX_W-1:0] cfg_index,
  input  logic [qhse_pkg::REG_W-1:0] cfg_wdata
);
  import qhse_pkg::*;

  coefs_t         coefs;
  logic           en;
  logic           s0_valid_r;
  logic [T_W-1:0] s0_t_r;
  logic [T_W-1:0] t_clamped;
  pipe_t          pipe_chain [NUM_STAGES+1];
  lanes_t         acc_chain  [NUM_STAGES+1];
  logic           res_valid;
  result_t        res;

  qhse_coef u_coef (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .coefs     (coefs)
  );

  assign en          = !res_valid || out_ch.ready;
  assign in_ch.ready = en;
  assign t_clamped   = (in_ch.param_t > T_ONE) ? T_ONE : in_ch.param_t;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
    end else if (en) begin
      s0_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_t_r <= t_clamped;
    end
  end

  assign pipe_chain[0].valid = s0_valid_r;
  assign pipe_chain[0].t     = s0_t_r;
  assign acc_chain[0]        = '0;

  for (genvar s = 0; s < NUM_STAGES; s++) begin : g_stage
    qhse_stage u_stage (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (en),
      .pipe_in  (pipe_chain[s]),
      .acc_prev (acc_chain[s]),
      .init     (stage_init(s, coefs)),
      .addend   (stage_add(s, coefs)),
      .start    (lane_start(s)),
      .on       (lane_on(s)),
      .pipe_out (pipe_chain[s+1]),
      .acc_out  (acc_chain[s+1])
    );
  end

  qhse_finish u_finish (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .valid_in  (pipe_chain[NUM_STAGES].valid),
    .acc_in    (acc_chain[NUM_STAGES]),
    .valid_out (res_valid),
    .result    (res)
  );

  assign out_ch.valid        = res_valid;
  assign out_ch.position     = res.position;
  assign out_ch.velocity     = res.velocity;
  assign out_ch.acceleration = res.acceleration;
  assign out_ch.jerk         = res.jerk;
  assign out_ch.clipped      = res.clipped;

`ifndef NO_ASSERTIONS
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && !out_ch.ready) |-> !in_ch.ready)
    else $error("input taken while result stalled");

  a_transfer_enters: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> s0_valid_r)
    else $error("input transfer lost at pipeline entry");

  a_t_clamped: assert property (@(posedge clk) disable iff (!rst_n)
    s0_valid_r |-> (s0_t_r <= T_ONE))
    else $error("parameter above one entered the pipeline");

  a_last_stage_advances: assert property (@(posedge clk) disable iff (!rst_n)
    (pipe_chain[NUM_STAGES].valid && en) |=> res_valid)
    else $error("item dropped at result register");
`endif

endmodule
